// ===== hdl/otpa_pkg.sv =====
// Package for the int8 outer-product tile accumulator.
// Holds widths, action and register codes, and the transaction structs.
// No dependencies.
`default_nettype none

package otpa_pkg;

    localparam int LANES        = 8;
    localparam int BYTE_W       = 8;
    localparam int PROD_W       = 2 * BYTE_W;
    localparam int SUM_W        = 32;
    localparam int CFG_W        = 4;
    localparam int ROW_W        = 3;
    localparam int ACT_W        = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int DEF_TILE_DIM = 8;

    localparam logic [CFG_W-1:0] CFG_RESET_COUNT = CFG_W'(8);

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ACCUM = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_IN_USE = 1'd0,
        REG_COLS_IN_USE = 1'd1
    } t_reg_idx;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic [LANES*BYTE_W-1:0] a_column;
        logic [LANES*BYTE_W-1:0] b_row;
        logic [ROW_W-1:0]        read_row;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]        row_index;
        logic signed [SUM_W-1:0] sum_lane0;
        logic signed [SUM_W-1:0] sum_lane1;
        logic signed [SUM_W-1:0] sum_lane2;
        logic signed [SUM_W-1:0] sum_lane3;
        logic signed [SUM_W-1:0] sum_lane4;
        logic signed [SUM_W-1:0] sum_lane5;
        logic signed [SUM_W-1:0] sum_lane6;
        logic signed [SUM_W-1:0] sum_lane7;
    } t_out_item;

    typedef struct packed {
        logic clear;
        logic accum;
    } t_tile_ctrl;

endpackage

`default_nettype wire

// ===== hdl/otpa_tile.sv =====
// Tile of TILE_DIM x TILE_DIM signed 32-bit accumulators, one 8x8 MAC per cell.
// Also selects and masks one row for readout. Depends on otpa_pkg.
`default_nettype none

module otpa_tile #(
    parameter int TILE_DIM = otpa_pkg::DEF_TILE_DIM
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    input  wire otpa_pkg::t_tile_ctrl                           i_ctrl,
    input  wire logic [otpa_pkg::LANES*otpa_pkg::BYTE_W-1:0]    i_a_column,
    input  wire logic [otpa_pkg::LANES*otpa_pkg::BYTE_W-1:0]    i_b_row,
    input  wire logic [otpa_pkg::CFG_W-1:0]                     i_rows,
    input  wire logic [otpa_pkg::CFG_W-1:0]                     i_cols,
    input  wire logic [otpa_pkg::ROW_W-1:0]                     i_read_row,
    output logic [otpa_pkg::LANES-1:0][otpa_pkg::SUM_W-1:0]     o_row_sums
);
    import otpa_pkg::*;

    logic [SUM_W-1:0] r_sum [TILE_DIM][TILE_DIM];

    for (genvar r = 0; r < TILE_DIM; r++) begin : g_row
        logic signed [BYTE_W-1:0] a_val;
        logic                     row_en;

        assign a_val  = signed'(i_a_column[r*BYTE_W +: BYTE_W]);
        assign row_en = CFG_W'(r) < i_rows;

        for (genvar c = 0; c < TILE_DIM; c++) begin : g_col
            logic signed [BYTE_W-1:0] b_val;
            logic signed [PROD_W-1:0] prod;
            logic                     col_en;
            logic [SUM_W-1:0]         n_sum;

            assign b_val  = signed'(i_b_row[c*BYTE_W +: BYTE_W]);
            assign prod   = a_val * b_val;
            assign col_en = CFG_W'(c) < i_cols;
            assign n_sum  = r_sum[r][c] + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sum[r][c] <= '0;
                end else if (i_ctrl.clear) begin
                    r_sum[r][c] <= '0;
                end else if (i_ctrl.accum && row_en && col_en) begin
                    r_sum[r][c] <= n_sum;
                end
            end
        end
    end

    for (genvar c = 0; c < LANES; c++) begin : g_read
        if (c < TILE_DIM) begin : g_live
            always_comb begin
                o_row_sums[c] = '0;
                if (CFG_W'(c) < i_cols) begin
                    for (int r = 0; r < TILE_DIM; r++) begin
                        if (i_read_row == ROW_W'(r)) begin
                            o_row_sums[c] = r_sum[r][c];
                        end
                    end
                end
            end
        end else begin : g_dead
            assign o_row_sums[c] = '0;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/otpa_out_stage.sv =====
// Output register for result transactions, held while the receiver stalls.
// Depends on otpa_pkg.
`default_nettype none

module otpa_out_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire otpa_pkg::t_out_item i_item,
    input  wire logic                i_stall,
    output logic                     o_valid,
    output otpa_pkg::t_out_item      o_item,
    output logic                     o_busy
);
    import otpa_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_busy  = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_busy) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_busy && i_load) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/int8_outer_product_tile_accumulator.sv =====
// Top level of the int8 outer-product tile accumulator.
// Instantiates otpa_tile and otpa_out_stage; depends on otpa_pkg.
//
// Input channel (i_in_valid / o_in_stall / i_in_item): each transaction carries
// an action: clear the tile, accumulate the outer product of a_column and
// b_row, or read one tile row. Output channel (o_out_valid / i_out_stall /
// o_out_item): one transaction per read, carrying the row index and eight sums.
// Configuration (i_cfg_we / i_cfg_idx / i_cfg_data) sets rows and columns in use.
// One transaction is accepted every cycle while o_in_stall is low. A transaction
// sits in the input register, where its MAC update or row select is done; a read
// result is then loaded into the output register, which drives o_out_valid.
// Clear and accumulate produce no result; a read following an accumulate sees
// its update. When the receiver stalls, the result holds in the output register
// and the input stalls only when a read waits behind it. Reset zeroes all
// accumulators, sets both counts to 8 and empties both registers.
`default_nettype none

module int8_outer_product_tile_accumulator #(
    parameter int TILE_DIM = otpa_pkg::DEF_TILE_DIM
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire otpa_pkg::t_in_item                i_in_item,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output otpa_pkg::t_out_item                    o_out_item,
    input  wire logic                              i_cfg_we,
    input  wire logic [otpa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [otpa_pkg::CFG_W-1:0]        i_cfg_data
);
    import otpa_pkg::*;

    logic                        r_in_valid;
    t_in_item                    r_in_item;
    logic [CFG_W-1:0]            r_rows;
    logic [CFG_W-1:0]            r_cols;

    t_tile_ctrl                  tile_ctrl;
    logic [LANES-1:0][SUM_W-1:0] row_sums;
    logic                        is_read;
    logic                        out_busy;
    logic                        hold;
    t_out_item                   res_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CFG_RESET_COUNT;
            r_cols <= CFG_RESET_COUNT;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_ROWS_IN_USE: r_rows <= i_cfg_data;
                REG_COLS_IN_USE: r_cols <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    assign is_read         = r_in_valid && (r_in_item.action == ACT_READ);
    assign hold            = is_read && out_busy;
    assign o_in_stall      = hold;
    assign tile_ctrl.clear = r_in_valid && (r_in_item.action == ACT_CLEAR);
    assign tile_ctrl.accum = r_in_valid && (r_in_item.action == ACT_ACCUM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!hold) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!hold && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    otpa_tile #(
        .TILE_DIM   (TILE_DIM)
    ) u_tile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (tile_ctrl),
        .i_a_column (r_in_item.a_column),
        .i_b_row    (r_in_item.b_row),
        .i_rows     (r_rows),
        .i_cols     (r_cols),
        .i_read_row (r_in_item.read_row),
        .o_row_sums (row_sums)
    );

    always_comb begin
        res_item.row_index = r_in_item.read_row;
        res_item.sum_lane0 = row_sums[0];
        res_item.sum_lane1 = row_sums[1];
        res_item.sum_lane2 = row_sums[2];
        res_item.sum_lane3 = row_sums[3];
        res_item.sum_lane4 = row_sums[4];
        res_item.sum_lane5 = row_sums[5];
        res_item.sum_lane6 = row_sums[6];
        res_item.sum_lane7 = row_sums[7];
    end

    otpa_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (is_read),
        .i_item  (res_item),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .o_busy  (out_busy)
    );

endmodule

`default_nettype wire
